### hw/rtl/lps_pkg.sv
// shared types, constants and helper functions for the led pattern sequencer
package lps_pkg;

    localparam int unsigned LED_W  = 8;
    localparam int unsigned MODE_W = 4;
    localparam int unsigned POS_W  = 3;

    localparam logic [MODE_W-1:0] MODE_BIN_UP  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BIN_DN  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_GRAY_UP = 4'd3;
    localparam logic [MODE_W-1:0] MODE_GRAY_DN = 4'd4;
    localparam logic [MODE_W-1:0] MODE_BCD_UP  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BCD_DN  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BOUNCE  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_STACK   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_LFSR    = 4'd9;
    localparam logic [MODE_W-1:0] MODE_FIRST   = MODE_BIN_UP;
    localparam logic [MODE_W-1:0] MODE_LAST    = MODE_LFSR;

    localparam logic [LED_W-1:0] SEED_DEFAULT = 8'h73;
    localparam logic [LED_W-1:0] BYTE_MASK    = 8'hFF;
    localparam logic [LED_W-1:0] LOW6_MASK    = 8'h3F;
    localparam logic [LED_W-1:0] BCD_MAX      = 8'd99;
    localparam logic [LED_W-1:0] BCD_BASE     = 8'd10;
    localparam logic [14:0]      BCD_RECIP    = 15'd205;
    localparam logic [POS_W-1:0] WINDOW_TOP   = 3'd5;
    localparam logic [LED_W-1:0] WINDOW_BITS  = 8'h07;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LED_W-1:0]  count;
        logic              bounce_dir;
        logic [POS_W-1:0]  bounce_pos;
        logic [POS_W-1:0]  runner_pos;
        logic [LED_W-1:0]  stacked_mask;
        logic [LED_W-1:0]  shift;
        logic              last_next;
        logic              last_prev;
    } lps_state_t;

    function automatic logic [LED_W-1:0] gray_of(input logic [LED_W-1:0] v);
        return v ^ (v >> 1);
    endfunction

    // valid for v up to 99: tens by reciprocal multiply
    function automatic logic [LED_W-1:0] bcd_of(input logic [LED_W-1:0] v);
        logic [14:0]      prod;
        logic [3:0]       tens;
        logic [LED_W-1:0] tens_x10;
        logic [3:0]       ones;
        prod     = 15'(v) * BCD_RECIP;
        tens     = prod[14:11];
        tens_x10 = 8'(tens) * BCD_BASE;
        ones     = 4'(v - tens_x10);
        return {tens, ones};
    endfunction

endpackage

### hw/rtl/lps_step.sv
// next-state and led frame logic for one tick
module lps_step
    import lps_pkg::*;
(
    input  lps_state_t        cur,
    input  logic              next_level,
    input  logic              prev_level,
    output lps_state_t        nxt,
    output logic [LED_W-1:0]  frame
);

    logic [MODE_W-1:0] mode_base;
    logic [MODE_W-1:0] mode_fwd;
    logic [MODE_W-1:0] mode_sel;
    logic [LED_W-1:0]  bcd_up_val;
    logic [LED_W-1:0]  bcd_dn_val;
    logic              stack_hit;
    logic [LED_W-1:0]  runner_bit;
    logic [LED_W-1:0]  mask_add;
    logic [POS_W-1:0]  runner_add;
    logic [LED_W-1:0]  lfsr_new;

    always_comb
    begin
        mode_base = (cur.mode < MODE_FIRST || cur.mode > MODE_LAST) ? MODE_FIRST : cur.mode;
        if (cur.last_next && !next_level)
        begin
            mode_fwd = (mode_base >= MODE_LAST) ? MODE_FIRST : mode_base + 4'd1;
        end
        else
        begin
            mode_fwd = mode_base;
        end
        if (cur.last_prev && !prev_level)
        begin
            mode_sel = (mode_fwd <= MODE_FIRST) ? MODE_LAST : mode_fwd - 4'd1;
        end
        else
        begin
            mode_sel = mode_fwd;
        end
    end

    assign bcd_up_val = (cur.count > BCD_MAX) ? '0 : cur.count;
    assign bcd_dn_val = (cur.count == BYTE_MASK || cur.count > BCD_MAX) ? BCD_MAX : cur.count;

    assign runner_bit = 8'd1 << cur.runner_pos;
    assign stack_hit  = (cur.runner_pos == 3'd7) || cur.stacked_mask[cur.runner_pos + 3'd1];
    assign mask_add   = stack_hit ? (cur.stacked_mask | runner_bit) : cur.stacked_mask;
    assign runner_add = stack_hit ? '0 : cur.runner_pos + 3'd1;

    assign lfsr_new = {cur.shift[6:0],
                       cur.shift[0] ^ cur.shift[1] ^ cur.shift[4] ^ cur.shift[5] ^ cur.shift[6]};

    always_comb
    begin
        nxt           = cur;
        nxt.mode      = mode_sel;
        nxt.last_next = next_level;
        nxt.last_prev = prev_level;
        unique case (mode_sel)
            MODE_BIN_DN:
            begin
                frame     = cur.count;
                nxt.count = cur.count - 8'd1;
            end
            MODE_GRAY_UP:
            begin
                frame     = gray_of(cur.count);
                nxt.count = cur.count + 8'd1;
            end
            MODE_GRAY_DN:
            begin
                frame     = gray_of(cur.count);
                nxt.count = cur.count - 8'd1;
            end
            MODE_BCD_UP:
            begin
                frame     = bcd_of(bcd_up_val);
                nxt.count = bcd_up_val + 8'd1;
            end
            MODE_BCD_DN:
            begin
                frame     = bcd_of(bcd_dn_val);
                nxt.count = bcd_dn_val - 8'd1;
            end
            MODE_BOUNCE:
            begin
                frame = WINDOW_BITS << cur.bounce_pos;
                if (!cur.bounce_dir)
                begin
                    if (cur.bounce_pos < WINDOW_TOP)
                    begin
                        nxt.bounce_pos = cur.bounce_pos + 3'd1;
                    end
                    else
                    begin
                        nxt.bounce_dir = 1'b1;
                        nxt.bounce_pos = cur.bounce_pos - 3'd1;
                    end
                end
                else
                begin
                    if (cur.bounce_pos > 3'd0)
                    begin
                        nxt.bounce_pos = cur.bounce_pos - 3'd1;
                    end
                    else
                    begin
                        nxt.bounce_dir = 1'b0;
                        nxt.bounce_pos = cur.bounce_pos + 3'd1;
                    end
                end
            end
            MODE_STACK:
            begin
                if (mask_add == BYTE_MASK)
                begin
                    frame            = '0;
                    nxt.stacked_mask = '0;
                    nxt.runner_pos   = '0;
                end
                else
                begin
                    frame            = mask_add | (8'd1 << runner_add);
                    nxt.stacked_mask = mask_add;
                    nxt.runner_pos   = runner_add;
                end
            end
            MODE_LFSR:
            begin
                frame     = lfsr_new & LOW6_MASK;
                nxt.shift = lfsr_new;
            end
            default:
            begin
                frame     = cur.count;
                nxt.count = cur.count + 8'd1;
            end
        endcase
    end

endmodule

### hw/rtl/led_pattern_sequencer.sv
// led pattern sequencer top level: state registers, output register and handshakes
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_ready, next_level,       | in
//           | prev_level                            |
//  output   | out_valid, out_ready, leds, mode      | out
//  config   | cfg_we, cfg_data (lfsr seed)          | in
//
//  one tick per cycle while in_ready: a transfer updates the state registers and
//  loads the result register on the same edge, the result shows in the next cycle
//  in_ready is low only while a result is held and out_ready is low
//  reset puts mode 1, clears the counters and loads the default seed
//  a seed write reloads the shift register at once
module led_pattern_sequencer
    import lps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              next_level,
    input  logic              prev_level,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LED_W-1:0]  leds,
    output logic [MODE_W-1:0] mode,
    input  logic              cfg_we,
    input  logic [LED_W-1:0]  cfg_data
);

    lps_state_t        state_reg;
    lps_state_t        state_next;
    logic [LED_W-1:0]  frame_next;
    logic              out_valid_reg;
    logic [LED_W-1:0]  leds_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              in_xfer;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    lps_step u_step (
        .cur        (state_reg),
        .next_level (next_level),
        .prev_level (prev_level),
        .nxt        (state_next),
        .frame      (frame_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_FIRST;
            state_reg.count        <= '0;
            state_reg.bounce_dir   <= 1'b0;
            state_reg.bounce_pos   <= '0;
            state_reg.runner_pos   <= '0;
            state_reg.stacked_mask <= '0;
            state_reg.shift        <= SEED_DEFAULT;
            state_reg.last_next    <= 1'b1;
            state_reg.last_prev    <= 1'b1;
        end
        else if (cfg_we)
        begin
            state_reg.shift <= cfg_data;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            leds_reg <= frame_next;
            mode_reg <= state_next.mode;
        end
    end

    assign out_valid = out_valid_reg;
    assign leds      = leds_reg;
    assign mode      = mode_reg;

endmodule
